// ===== sv/ray_box_slab_intersect_top_defines.svh =====
// Assertion macros for the ray/box slab unit.
// Bodies expect signals named clock and reset in the using module.
`ifndef RAY_BOX_SLAB_INTERSECT_TOP_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define RBSI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define RBSI_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define RBSI_ASSERT(lbl, prop, msg)
`define RBSI_NEVER(lbl, cond, msg)
`endif
`endif

// ===== sv/rbsi_pkg.sv =====
package rbsi_pkg;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS       = 16;
   localparam int THR_WIDTH       = 16;
   localparam int FACE_WIDTH      = 3;
   localparam int TCAP_LOG2       = 62;
   localparam int PLIM_LOG2       = 50;
endpackage

// ===== sv/rbsi_div_pipe.sv =====
// Unsigned restoring divider, one quotient bit per stage, NW stages.
module rbsi_div_pipe #(
   parameter int NW = 48,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [NW-1:0] quo
);
   logic [DW-1:0] rem_ff  [NW];
   logic [NW-1:0] work_ff [NW];
   logic [DW-1:0] den_ff  [NW];

   genvar i;
   generate
      for (i = 0; i < NW; i++) begin : g_stage
         logic [DW-1:0] rem_prev;
         logic [NW-1:0] work_prev;
         logic [DW-1:0] den_prev;
         logic [DW:0]   trial;
         logic          ge;
         logic [DW-1:0] rem_in;
         logic [NW-1:0] work_in;
         if (i == 0) begin : g_first
            assign rem_prev  = '0;
            assign work_prev = num;
            assign den_prev  = den;
         end else begin : g_next
            assign rem_prev  = rem_ff[i-1];
            assign work_prev = work_ff[i-1];
            assign den_prev  = den_ff[i-1];
         end
         assign trial   = {rem_prev, work_prev[NW-1]};
         assign ge      = trial >= {1'b0, den_prev};
         // remainder stays below den, so the difference fits DW bits
         assign rem_in  = ge ? DW'(trial - {1'b0, den_prev}) : trial[DW-1:0];
         assign work_in = {work_prev[NW-2:0], ge};
         always_ff @(posedge clock) begin
            rem_ff[i]  <= rem_in;
            work_ff[i] <= work_in;
            den_ff[i]  <= den_prev;
         end
      end
   endgenerate

   assign quo = work_ff[NW-1];
endmodule

// ===== sv/ray_box_slab_intersect_top.sv =====
// Channel   Ports                         Handshake
// request   start, busy, req_*            beat taken when start && !busy
// result    rsp_strobe, rsp_*             one-cycle strobe, no back-pressure
// config    csr_write_enable, csr_*_data  written on the enable edge
//
// Fully pipelined: one beat per cycle, busy is always low.
// The slab divides resolve one quotient bit per stage over COORD_WIDTH + 16 bits.
// Synchronous reset clears the valid bits and the threshold register.
// The receiver cannot stall, so the pipeline never holds.
module ray_box_slab_intersect_top
   import rbsi_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_origin_x,
   input  logic signed [COORD_WIDTH-1:0] req_origin_y,
   input  logic signed [COORD_WIDTH-1:0] req_origin_z,
   input  logic signed [COORD_WIDTH-1:0] req_dir_x,
   input  logic signed [COORD_WIDTH-1:0] req_dir_y,
   input  logic signed [COORD_WIDTH-1:0] req_dir_z,
   input  logic signed [COORD_WIDTH-1:0] req_corner_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_corner_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_corner_a_z,
   input  logic signed [COORD_WIDTH-1:0] req_corner_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_corner_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_corner_b_z,
   input  logic                          csr_write_enable,
   input  logic [THR_WIDTH-1:0]          csr_write_data,
   output logic                          rsp_strobe,
   output logic                          rsp_hit,
   output logic [COORD_WIDTH-2:0]        rsp_distance,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_x,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_y,
   output logic signed [COORD_WIDTH-1:0] rsp_hit_z,
   output logic [FACE_WIDTH-1:0]         rsp_face
);
`include "ray_box_slab_intersect_top_defines.svh"

   localparam int W   = COORD_WIDTH;
   localparam int QW  = W + FRAC_BITS;
   localparam int MW  = (QW > 64) ? QW : 64;
   localparam int TW  = 64;
   localparam int H   = W / 2;
   localparam int FW  = 2 * W - 1;
   localparam int MLW = PLIM_LOG2 + 1;
   localparam int SW  = (FW > MLW) ? FW : MLW;
   localparam int AW  = ((W > MLW) ? W : MLW) + 2;
   localparam int LAT = QW + 12;

   localparam logic [MW-1:0]        TCAP_M = MW'(1) << TCAP_LOG2;
   localparam logic signed [TW-1:0] TCAP_T = TW'(1) << TCAP_LOG2;
   localparam logic signed [TW-1:0] CMAX_T = (TW'(1) << (W - 1)) - TW'(1);
   localparam logic [SW-1:0]        PLIM_S = SW'(1) << PLIM_LOG2;
   localparam logic signed [AW-1:0] PMAX_A = (AW'(1) << (W - 1)) - AW'(1);
   localparam logic signed [AW-1:0] PMIN_A = ~PMAX_A;

   typedef struct packed {
      logic [2:0][W-1:0] org;
      logic [2:0][W-1:0] lo;
      logic [2:0][W-1:0] hi;
      logic [2:0][W-1:0] dmag;
      logic [2:0]        dneg;
      logic [2:0]        par;
      logic [2:0]        in_slab;
      logic [5:0]        qneg;
   } side_type;

   logic [THR_WIDTH-1:0] threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (csr_write_enable) begin
         threshold_ff <= csr_write_data;
      end
   end

   assign busy = 1'b0;

   // ---- stage 0: capture and sort corners
   logic                s0_vld_ff;
   logic signed [W-1:0] s0_org_ff [3];
   logic signed [W-1:0] s0_dir_ff [3];
   logic signed [W-1:0] s0_lo_ff  [3];
   logic signed [W-1:0] s0_hi_ff  [3];
   logic signed [W-1:0] in_org [3];
   logic signed [W-1:0] in_dir [3];
   logic signed [W-1:0] in_a   [3];
   logic signed [W-1:0] in_b   [3];

   assign in_org = '{req_origin_x, req_origin_y, req_origin_z};
   assign in_dir = '{req_dir_x, req_dir_y, req_dir_z};
   assign in_a   = '{req_corner_a_x, req_corner_a_y, req_corner_a_z};
   assign in_b   = '{req_corner_b_x, req_corner_b_y, req_corner_b_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         s0_org_ff[k] <= in_org[k];
         s0_dir_ff[k] <= in_dir[k];
         s0_lo_ff[k]  <= (in_a[k] < in_b[k]) ? in_a[k] : in_b[k];
         s0_hi_ff[k]  <= (in_a[k] < in_b[k]) ? in_b[k] : in_a[k];
      end
   end

   // ---- stage 1: slab numerators, magnitudes, parallel test
   logic                s1_vld_ff;
   side_type            side1_ff;
   side_type            side1_in;
   logic [W-1:0]        un1_ff [6];
   logic [W-1:0]        un1_in [6];
   logic signed [W:0]   diff1  [6];
   logic [W:0]          dmag1  [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff1[2*k]   = (W+1)'(s0_lo_ff[k]) - (W+1)'(s0_org_ff[k]);
         diff1[2*k+1] = (W+1)'(s0_hi_ff[k]) - (W+1)'(s0_org_ff[k]);
         dmag1[k]     = s0_dir_ff[k][W-1] ? -(W+1)'(s0_dir_ff[k]) : (W+1)'(s0_dir_ff[k]);
         side1_in.org[k]     = s0_org_ff[k];
         side1_in.lo[k]      = s0_lo_ff[k];
         side1_in.hi[k]      = s0_hi_ff[k];
         side1_in.dmag[k]    = dmag1[k][W-1:0];
         side1_in.dneg[k]    = s0_dir_ff[k][W-1];
         side1_in.par[k]     = dmag1[k][W-1:0] <= W'(threshold_ff);
         side1_in.in_slab[k] = (s0_org_ff[k] >= s0_lo_ff[k]) && (s0_org_ff[k] <= s0_hi_ff[k]);
      end
      for (int j = 0; j < 6; j++) begin
         un1_in[j]        = diff1[j][W] ? W'(-diff1[j]) : W'(diff1[j]);
         side1_in.qneg[j] = diff1[j][W] ^ s0_dir_ff[j/2][W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      side1_ff <= side1_in;
      un1_ff   <= un1_in;
   end

   // ---- slab dividers with side data delay line
   logic [QW-1:0] div_q [6];

   genvar gj;
   generate
      for (gj = 0; gj < 6; gj++) begin : g_div
         rbsi_div_pipe #(
            .NW(QW),
            .DW(W)
         ) u_div (
            .clock(clock),
            .num  ({un1_ff[gj], FRAC_BITS'(0)}),
            .den  (side1_ff.dmag[gj/2]),
            .quo  (div_q[gj])
         );
      end
   endgenerate

   side_type      side_dl_ff [QW];
   logic [QW-1:0] vld_dl_ff;

   always_ff @(posedge clock) begin
      side_dl_ff[0] <= side1_ff;
      for (int i = 1; i < QW; i++) begin
         side_dl_ff[i] <= side_dl_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_dl_ff <= '0;
      end else begin
         vld_dl_ff <= {vld_dl_ff[QW-2:0], s1_vld_ff};
      end
   end

   // ---- stage A: saturate and sign slab distances
   logic                 a_vld_ff;
   side_type             side_a_ff;
   logic signed [TW-1:0] ta_ff [6];
   logic signed [TW-1:0] ta_in [6];
   logic [MW-1:0]        qx    [6];
   logic [MW-1:0]        qm    [6];

   always_comb begin
      for (int j = 0; j < 6; j++) begin
         qx[j]    = MW'(div_q[j]);
         qm[j]    = (qx[j] > TCAP_M) ? TCAP_M : qx[j];
         ta_in[j] = side_dl_ff[QW-1].qneg[j] ? -TW'(qm[j]) : TW'(qm[j]);
      end
   end

   // ---- stage S: order near/far per axis
   logic                 sw_vld_ff;
   side_type             side_s_ff;
   logic signed [TW-1:0] tn_ff [3];
   logic signed [TW-1:0] tf_ff [3];

   // ---- stage B: interval reduction
   logic                 b_vld_ff;
   side_type             side_b_ff;
   logic signed [TW-1:0] tmin_ff, tmax_ff;
   logic signed [TW-1:0] en [3];
   logic signed [TW-1:0] ef [3];
   logic signed [TW-1:0] mx01, mx2, mn01, mn2;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         en[k] = side_s_ff.par[k] ? TW'(0) : tn_ff[k];
         ef[k] = side_s_ff.par[k] ? TCAP_T : tf_ff[k];
      end
      mx01 = (en[1] > en[0]) ? en[1] : en[0];
      mx2  = (en[2] > TW'(0)) ? en[2] : TW'(0);
      mn01 = (ef[1] < ef[0]) ? ef[1] : ef[0];
      mn2  = (ef[2] < TCAP_T) ? ef[2] : TCAP_T;
   end

   // ---- stage C: hit decision and clamped distance
   logic           c_vld_ff;
   side_type       side_c_ff;
   logic           c_hit_ff;
   logic [W-2:0]   c_dist_ff;

   // ---- stage D: partial products dist * |dir|
   localparam int PLW = W - 1 + H;
   localparam int PHW = W - 1 + (W - H);
   logic           d_vld_ff;
   side_type       side_d_ff;
   logic           d_hit_ff;
   logic [W-2:0]   d_dist_ff;
   logic [PLW-1:0] pl_ff [3];
   logic [PHW-1:0] ph_ff [3];

   // ---- stage E: combine, scale, clamp
   logic           e_vld_ff;
   side_type       side_e_ff;
   logic           e_hit_ff;
   logic [W-2:0]   e_dist_ff;
   logic [MLW-1:0] m_ff [3];
   logic [MLW-1:0] m_in [3];
   logic [FW-1:0]  full [3];
   logic [SW-1:0]  sx   [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         full[k] = FW'(pl_ff[k]) + (FW'(ph_ff[k]) << H);
         sx[k]   = SW'(full[k] >> FRAC_BITS);
         m_in[k] = (sx[k] > PLIM_S) ? PLIM_S[MLW-1:0] : sx[k][MLW-1:0];
      end
   end

   // ---- stage F: hit position
   logic                 f_vld_ff;
   side_type             side_f_ff;
   logic                 f_hit_ff;
   logic [W-2:0]         f_dist_ff;
   logic signed [W-1:0]  pos_ff [3];
   logic signed [W-1:0]  pos_in [3];
   logic signed [AW-1:0] sm     [3];
   logic signed [AW-1:0] psum   [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sm[k]   = side_e_ff.dneg[k] ? -$signed(AW'(m_ff[k])) : $signed(AW'(m_ff[k]));
         psum[k] = AW'($signed(side_e_ff.org[k])) + sm[k];
         if (psum[k] > PMAX_A) begin
            pos_in[k] = PMAX_A[W-1:0];
         end else if (psum[k] < PMIN_A) begin
            pos_in[k] = PMIN_A[W-1:0];
         end else begin
            pos_in[k] = psum[k][W-1:0];
         end
      end
   end

   // ---- stage G: face distances
   logic                g_vld_ff;
   logic                g_hit_ff;
   logic [W-2:0]        g_dist_ff;
   logic signed [W-1:0] g_pos_ff [3];
   logic [W:0]          dd_ff [6];
   logic [W:0]          dd_in [6];
   logic signed [W:0]   fdiff [6];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         fdiff[2*k]   = (W+1)'(pos_ff[k]) - (W+1)'($signed(side_f_ff.lo[k]));
         fdiff[2*k+1] = (W+1)'(pos_ff[k]) - (W+1)'($signed(side_f_ff.hi[k]));
      end
      for (int j = 0; j < 6; j++) begin
         dd_in[j] = fdiff[j][W] ? -fdiff[j] : fdiff[j];
      end
   end

   // ---- stage H: nearest face per axis, low face wins ties
   logic                h_vld_ff;
   logic                h_hit_ff;
   logic [W-2:0]        h_dist_ff;
   logic signed [W-1:0] h_pos_ff [3];
   logic [W:0]          best_ff [3];
   logic [2:0]          sel_ff;

   // ---- output stage: nearest axis, earliest axis wins ties
   logic                  o_vld_ff;
   logic                  o_hit_ff;
   logic [W-2:0]          o_dist_ff;
   logic signed [W-1:0]   o_pos_ff [3];
   logic [FACE_WIDTH-1:0] o_face_ff;
   logic [1:0]            ax_sel;
   logic [W:0]            b01;

   always_comb begin
      ax_sel = 2'd0;
      b01    = best_ff[0];
      if (best_ff[1] < b01) begin
         ax_sel = 2'd1;
         b01    = best_ff[1];
      end
      if (best_ff[2] < b01) begin
         ax_sel = 2'd2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff  <= 1'b0;
         sw_vld_ff <= 1'b0;
         b_vld_ff  <= 1'b0;
         c_vld_ff  <= 1'b0;
         d_vld_ff  <= 1'b0;
         e_vld_ff  <= 1'b0;
         f_vld_ff  <= 1'b0;
         g_vld_ff  <= 1'b0;
         h_vld_ff  <= 1'b0;
         o_vld_ff  <= 1'b0;
      end else begin
         a_vld_ff  <= vld_dl_ff[QW-1];
         sw_vld_ff <= a_vld_ff;
         b_vld_ff  <= sw_vld_ff;
         c_vld_ff  <= b_vld_ff;
         d_vld_ff  <= c_vld_ff;
         e_vld_ff  <= d_vld_ff;
         f_vld_ff  <= e_vld_ff;
         g_vld_ff  <= f_vld_ff;
         h_vld_ff  <= g_vld_ff;
         o_vld_ff  <= h_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      // A
      side_a_ff <= side_dl_ff[QW-1];
      ta_ff     <= ta_in;
      // S
      side_s_ff <= side_a_ff;
      for (int k = 0; k < 3; k++) begin
         tn_ff[k] <= (ta_ff[2*k] > ta_ff[2*k+1]) ? ta_ff[2*k+1] : ta_ff[2*k];
         tf_ff[k] <= (ta_ff[2*k] > ta_ff[2*k+1]) ? ta_ff[2*k] : ta_ff[2*k+1];
      end
      // B
      side_b_ff <= side_s_ff;
      tmin_ff   <= (mx2 > mx01) ? mx2 : mx01;
      tmax_ff   <= (mn2 < mn01) ? mn2 : mn01;
      // C
      side_c_ff <= side_b_ff;
      c_hit_ff  <= !(|(side_b_ff.par & ~side_b_ff.in_slab)) && !(tmax_ff < tmin_ff);
      c_dist_ff <= (tmin_ff > CMAX_T) ? CMAX_T[W-2:0] : tmin_ff[W-2:0];
      // D
      side_d_ff <= side_c_ff;
      d_hit_ff  <= c_hit_ff;
      d_dist_ff <= c_dist_ff;
      for (int k = 0; k < 3; k++) begin
         pl_ff[k] <= PLW'(c_dist_ff) * PLW'(side_c_ff.dmag[k][H-1:0]);
         ph_ff[k] <= PHW'(c_dist_ff) * PHW'(side_c_ff.dmag[k][W-1:H]);
      end
      // E
      side_e_ff <= side_d_ff;
      e_hit_ff  <= d_hit_ff;
      e_dist_ff <= d_dist_ff;
      m_ff      <= m_in;
      // F
      side_f_ff <= side_e_ff;
      f_hit_ff  <= e_hit_ff;
      f_dist_ff <= e_dist_ff;
      pos_ff    <= pos_in;
      // G
      g_hit_ff  <= f_hit_ff;
      g_dist_ff <= f_dist_ff;
      g_pos_ff  <= pos_ff;
      dd_ff     <= dd_in;
      // H
      h_hit_ff  <= g_hit_ff;
      h_dist_ff <= g_dist_ff;
      h_pos_ff  <= g_pos_ff;
      for (int k = 0; k < 3; k++) begin
         sel_ff[k]  <= dd_ff[2*k+1] < dd_ff[2*k];
         best_ff[k] <= (dd_ff[2*k+1] < dd_ff[2*k]) ? dd_ff[2*k+1] : dd_ff[2*k];
      end
      // output, miss beats carry zeros
      o_hit_ff  <= h_hit_ff;
      o_dist_ff <= h_hit_ff ? h_dist_ff : '0;
      for (int k = 0; k < 3; k++) begin
         o_pos_ff[k] <= h_hit_ff ? h_pos_ff[k] : '0;
      end
      o_face_ff <= h_hit_ff ? {ax_sel, sel_ff[ax_sel]} : '0;
   end

   assign rsp_strobe   = o_vld_ff;
   assign rsp_hit      = o_hit_ff;
   assign rsp_distance = o_dist_ff;
   assign rsp_hit_x    = o_pos_ff[0];
   assign rsp_hit_y    = o_pos_ff[1];
   assign rsp_hit_z    = o_pos_ff[2];
   assign rsp_face     = o_face_ff;

   `RBSI_ASSERT(a_latency_fwd, start |-> ##LAT rsp_strobe, "accepted beat did not emerge")
   `RBSI_ASSERT(a_latency_back, rsp_strobe |-> $past(start, LAT), "result without request")
   `RBSI_ASSERT(a_miss_zero, (rsp_strobe && !rsp_hit) |-> (rsp_distance == 0 && rsp_face == 0 && rsp_hit_x == 0 && rsp_hit_y == 0 && rsp_hit_z == 0), "miss fields not zero")
   `RBSI_NEVER(a_face_range, rsp_strobe && rsp_face > 3'd5, "face code out of range")
endmodule

// ===== sim/ray_box_slab_intersect_top_test.sv =====
`timescale 1ns / 1ps

module ray_box_slab_intersect_top_test
   import rbsi_pkg::*;
();

   localparam int CW = COORD_WIDTH_DEF;
   localparam int LATENCY = CW + 28;
   localparam int NUM_RANDOM = 1800;
   localparam longint CYCLE_LIMIT = 400000;
   localparam logic [63:0] T_CAP = 64'd1 << TCAP_LOG2;
   localparam logic [63:0] P_CAP = 64'd1 << PLIM_LOG2;
   localparam longint C_MAX = (longint'(1) << (CW - 1)) - 1;
   localparam longint C_MIN = -C_MAX - 1;
   localparam logic [2:0] FACE_XN = 3'd0, FACE_XP = 3'd1, FACE_YN = 3'd2,
                          FACE_YP = 3'd3, FACE_ZN = 3'd4, FACE_ZP = 3'd5;
   localparam logic [31:0] MAXP = 32'h7fffffff, MAXN = 32'h80000000;

   typedef struct {
      logic signed [CW-1:0] org [3];
      logic signed [CW-1:0] dir [3];
      logic signed [CW-1:0] ca  [3];
      logic signed [CW-1:0] cb  [3];
   } ray_box_type;

   typedef struct {
      logic                 hit;
      logic [CW-2:0]        distance;
      logic signed [CW-1:0] pos [3];
      logic [2:0]           face;
   } slab_hit_type;

   logic clock = 0, reset = 1, start = 0, busy;
   logic signed [CW-1:0] req_origin_x = 0, req_origin_y = 0, req_origin_z = 0;
   logic signed [CW-1:0] req_dir_x = 0, req_dir_y = 0, req_dir_z = 0;
   logic signed [CW-1:0] req_corner_a_x = 0, req_corner_a_y = 0, req_corner_a_z = 0;
   logic signed [CW-1:0] req_corner_b_x = 0, req_corner_b_y = 0, req_corner_b_z = 0;
   logic csr_write_enable = 0;
   logic [THR_WIDTH-1:0] csr_write_data = 0;
   logic rsp_strobe, rsp_hit;
   logic [CW-2:0] rsp_distance;
   logic signed [CW-1:0] rsp_hit_x, rsp_hit_y, rsp_hit_z;
   logic [FACE_WIDTH-1:0] rsp_face;

   ray_box_slab_intersect_top i_dut (.*);

   initial forever #5 clock = ~clock;

   logic [63:0] par_thr = 0;
   slab_hit_type pending_hits [$];
   int mismatches = 0, hits_seen = 0, beats_out = 0;
   longint cycles = 0;
   int sender_idle = 0;

   function automatic logic [63:0] magn(longint x);
      return x < 0 ? 64'(-x) : 64'(x);
   endfunction

   function automatic longint slab_t(longint num, longint den);
      logic [63:0] un, ud, q1, r, m;
      un = magn(num); ud = magn(den);
      q1 = un / ud; r = un % ud;
      if (q1 >= (T_CAP >> 16)) m = T_CAP;
      else begin
         m = (q1 << 16) + ((r << 16) / ud);
         if (m > T_CAP) m = T_CAP;
      end
      return ((num < 0) != (den < 0)) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint travel(longint t, longint d);
      logic [63:0] ud, ti, tf, m;
      ud = magn(d); ti = 64'(t) >> 16; tf = 64'(t) & 64'hffff;
      if (ti != 0 && ud > P_CAP / ti) m = P_CAP;
      else begin
         m = ti * ud + ((tf * ud) >> 16);
         if (m > P_CAP) m = P_CAP;
      end
      return d < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic slab_hit_type slab_predict(ray_box_type rb);
      slab_hit_type res;
      longint o [3], d [3], lo [3], hi [3], p [3];
      longint tmin, tmax, t0, t1, s, t_near, dd;
      logic [63:0] best;
      logic ok;
      ok = 1; tmin = 0; tmax = longint'(T_CAP); best = 0;
      res.hit = 0; res.distance = 0; res.face = FACE_XN;
      for (int k = 0; k < 3; k++) begin
         res.pos[k] = 0;
         o[k] = rb.org[k]; d[k] = rb.dir[k];
         lo[k] = rb.ca[k] < rb.cb[k] ? rb.ca[k] : rb.cb[k];
         hi[k] = rb.ca[k] < rb.cb[k] ? rb.cb[k] : rb.ca[k];
      end
      for (int k = 0; k < 3 && ok; k++) begin
         if (magn(d[k]) <= par_thr) begin
            if (o[k] < lo[k] || o[k] > hi[k]) ok = 0;
         end else begin
            t0 = slab_t(lo[k] - o[k], d[k]);
            t1 = slab_t(hi[k] - o[k], d[k]);
            if (t0 > t1) begin s = t0; t0 = t1; t1 = s; end
            if (t0 > tmin) tmin = t0;
            if (t1 < tmax) tmax = t1;
            if (tmax < tmin) ok = 0;
         end
      end
      if (!ok) return res;
      t_near = tmin > C_MAX ? C_MAX : tmin;
      for (int k = 0; k < 3; k++) begin
         p[k] = o[k] + travel(t_near, d[k]);
         if (p[k] > C_MAX) p[k] = C_MAX;
         if (p[k] < C_MIN) p[k] = C_MIN;
         res.pos[k] = p[k][CW-1:0];
      end
      // ties keep the earlier face
      for (int k = 0; k < 6; k++) begin
         dd = p[k >> 1] - ((k & 1) ? hi[k >> 1] : lo[k >> 1]);
         if (k == 0 || magn(dd) < best) begin best = magn(dd); res.face = 3'(k); end
      end
      res.hit = 1;
      res.distance = t_near[CW-2:0];
      return res;
   endfunction

   function automatic logic same_hit(slab_hit_type a, slab_hit_type b);
      return a.hit === b.hit && a.distance === b.distance && a.pos[0] === b.pos[0]
         && a.pos[1] === b.pos[1] && a.pos[2] === b.pos[2] && a.face === b.face;
   endfunction

   function automatic ray_box_type rb_make(logic [31:0] ox, oy, oz, dx, dy, dz,
                                           ax, ay, az, bx, by, bz);
      ray_box_type rb;
      rb.org = '{ox, oy, oz}; rb.dir = '{dx, dy, dz};
      rb.ca = '{ax, ay, az}; rb.cb = '{bx, by, bz};
      return rb;
   endfunction

   function automatic logic [31:0] rnd_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
         2: return 32'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
         default: return $urandom_range(0, 1) ? MAXP - $urandom_range(0, 3)
                                               : MAXN + $urandom_range(0, 3);
      endcase
   endfunction

   function automatic ray_box_type rb_random();
      ray_box_type rb;
      int mode;
      mode = $urandom_range(0, 9);
      mode = mode < 6 ? 1 : mode < 8 ? 0 : mode < 9 ? 2 : 3;
      for (int k = 0; k < 3; k++) begin
         rb.org[k] = rnd_coord(mode);
         rb.ca[k] = rnd_coord(mode);
         rb.cb[k] = rnd_coord(mode);
         rb.dir[k] = $urandom_range(0, 7) == 0 ? 32'($signed($urandom_range(0, 8)) - 4)
                   : rnd_coord($urandom_range(0, 3) == 0 ? 2 : mode);
      end
      // aim most mode-1 rays at the box center so hits are common
      if ($urandom_range(0, 2) != 0 && mode == 1)
         for (int k = 0; k < 3; k++)
            rb.dir[k] = 32'((longint'(rb.ca[k]) + rb.cb[k]) / 2 - rb.org[k]);
      return rb;
   endfunction

   // leaves start high; the caller drops it when the burst ends
   task automatic send_beat(ray_box_type rb);
      while (sender_idle > 0 && $urandom_range(0, 99) < sender_idle) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      {req_origin_x, req_origin_y, req_origin_z} <= {rb.org[0], rb.org[1], rb.org[2]};
      {req_dir_x, req_dir_y, req_dir_z} <= {rb.dir[0], rb.dir[1], rb.dir[2]};
      {req_corner_a_x, req_corner_a_y, req_corner_a_z} <= {rb.ca[0], rb.ca[1], rb.ca[2]};
      {req_corner_b_x, req_corner_b_y, req_corner_b_z} <= {rb.cb[0], rb.cb[1], rb.cb[2]};
      do @(posedge clock); while (busy);
      pending_hits.push_back(slab_predict(rb));
      @(negedge clock);
   endtask

   task automatic drain_and_set(logic [15:0] thr);
      start <= 0;
      while (pending_hits.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      csr_write_enable <= 1; csr_write_data <= thr;
      @(negedge clock);
      csr_write_enable <= 0;
      par_thr = thr;
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb: failure");
         $finish;
      end
      if (!reset && rsp_strobe) begin
         slab_hit_type exp_hit;
         logic bad;
         beats_out++;
         if (rsp_hit) hits_seen++;
         if (pending_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
         end else begin
            exp_hit = pending_hits.pop_front();
            bad = rsp_hit !== exp_hit.hit || rsp_distance !== exp_hit.distance
               || rsp_hit_x !== exp_hit.pos[0] || rsp_hit_y !== exp_hit.pos[1]
               || rsp_hit_z !== exp_hit.pos[2] || rsp_face !== exp_hit.face;
            if (bad) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch beat %0d: exp hit %0d t %h pos %h %h %h face %0d, got hit %0d t %h pos %h %h %h face %0d",
                     beats_out, exp_hit.hit, exp_hit.distance, exp_hit.pos[0], exp_hit.pos[1],
                     exp_hit.pos[2], exp_hit.face, rsp_hit, rsp_distance, rsp_hit_x,
                     rsp_hit_y, rsp_hit_z, rsp_face);
            end
         end
      end
   end

   // directed rows; expected typed in only for obvious ones
   typedef struct {
      ray_box_type  rb;
      logic         known;
      slab_hit_type want;
   } stim_row_type;

   stim_row_type dir_rows [$];

   function automatic slab_hit_type hit_at(logic h, logic [30:0] t, logic [31:0] x, y, z,
                                           logic [2:0] f);
      slab_hit_type r;
      r.hit = h; r.distance = t; r.pos = '{x, y, z}; r.face = f;
      return r;
   endfunction

   task automatic add_row(ray_box_type rb, logic known, slab_hit_type want);
      stim_row_type row;
      row.rb = rb; row.known = known; row.want = want;
      dir_rows.push_back(row);
   endtask

   initial begin
      slab_hit_type none, got;
      logic [15:0] thr_list [5];
      none = hit_at(0, 0, 0, 0, 0, FACE_XN);
      thr_list = '{16'hffff, 16'h0001, 16'h0100, 16'h0000, 16'h8000};
      repeat (8) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // origin inside a unit box, zero direction: parallel on all axes, hit at t=0
      add_row(rb_make(0, 0, 0, 0, 0, 0, 32'hffff0000, 32'hffff0000, 32'hffff0000,
                      32'h10000, 32'h10000, 32'h10000), 1,
              hit_at(1, 0, 0, 0, 0, FACE_XN));
      // parallel outside slab: miss
      add_row(rb_make(32'h50000, 0, 0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000, 32'h10000,
                      32'h10000), 1, none);
      // +x ray hitting -x face at t=2
      add_row(rb_make(0, 32'h8000, 32'h8000, 32'h10000, 0, 0, 32'h20000, 0, 0,
                      32'h30000, 32'h10000, 32'h10000), 1,
              hit_at(1, 31'h20000, 32'h20000, 32'h8000, 32'h8000, FACE_XN));
      // box behind the ray: miss
      add_row(rb_make(0, 0, 0, 32'h10000, 0, 0, 32'hfffd0000, 32'hffff0000, 32'hffff0000,
                      32'hfffe0000, 32'h10000, 32'h10000), 1, none);
      // degenerate box, swapped corners, all extremes
      add_row(rb_make(MAXN, MAXP, 0, MAXP, MAXN, 1, MAXP, MAXN, 0, MAXN, MAXP, 0), 0, none);
      add_row(rb_make(MAXP, MAXP, MAXP, MAXN, MAXN, MAXN, MAXN, MAXN, MAXN, MAXP, MAXP,
                      MAXP), 0, none);
      add_row(rb_make(MAXN, MAXN, MAXN, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP, 0, 0, 0), 0, none);
      add_row(rb_make(0, 0, 0, 1, 1, 1, MAXP, MAXP, MAXP, MAXP, MAXP, MAXP), 0, none);
      add_row(rb_make(0, 0, 0, 32'hffffffff, 32'hfffffffe, 1, MAXN, MAXN, MAXN, 32'hffff0000,
                      32'hffff0000, 32'hffff0000), 0, none);
      // faces and ties: each direction along each axis, corner hit
      add_row(rb_make(32'h50000, 0, 0, 32'hffff0000, 0, 0, 32'hffff0000, 32'hffff0000,
                      32'hffff0000, 32'h10000, 32'h10000, 32'h10000), 0, none);
      add_row(rb_make(0, 32'hfffb0000, 0, 0, 32'h10000, 0, 32'hffff0000, 32'hffff0000,
                      32'hffff0000, 32'h10000, 32'h10000, 32'h10000), 0, none);
      add_row(rb_make(0, 32'h50000, 0, 0, 32'hffff0000, 0, 32'hffff0000, 32'hffff0000,
                      32'hffff0000, 32'h10000, 32'h10000, 32'h10000), 0, none);
      add_row(rb_make(0, 0, 32'hfffb0000, 0, 0, 32'h10000, 32'hffff0000, 32'hffff0000,
                      32'hffff0000, 32'h10000, 32'h10000, 32'h10000), 0, none);
      add_row(rb_make(0, 0, 32'h50000, 0, 0, 32'hffff0000, 32'hffff0000, 32'hffff0000,
                      32'hffff0000, 32'h10000, 32'h10000, 32'h10000), 0, none);
      add_row(rb_make(32'hfffb0000, 32'hfffb0000, 32'hfffb0000, 32'h10000, 32'h10000,
                      32'h10000, 32'hffff0000, 32'hffff0000, 32'hffff0000, 32'h10000,
                      32'h10000, 32'h10000), 0, none);
      // on the bound, parallel with small direction
      add_row(rb_make(32'h10000, 0, 0, 1, 32'h10000, 0, 32'hffff0000, 32'hffff0000,
                      32'hffff0000, 32'h10000, 32'h10000, 32'h10000), 0, none);

      foreach (dir_rows[i]) begin
         got = slab_predict(dir_rows[i].rb);
         if (dir_rows[i].known && !same_hit(got, dir_rows[i].want)) begin
            mismatches++;
            if (mismatches <= 10) $display("directed row %0d disagrees with hand value", i);
         end
         send_beat(dir_rows[i].rb);
      end
      // same rows again under the largest threshold
      drain_and_set(16'hffff);
      foreach (dir_rows[i]) send_beat(dir_rows[i].rb);

      for (int ph = 0; ph < 5; ph++) begin
         drain_and_set(thr_list[(ph + 1) % 5]);
         case (ph)
            0: sender_idle = 0;
            1: sender_idle = 49;
            2: sender_idle = 17;
            3: sender_idle = 0;
            default: sender_idle = 49;
         endcase
         for (int n = 0; n < NUM_RANDOM / 5; n++) begin
            if (ph == 3 && (n % 50) < 25) sender_idle = 0;
            else if (ph == 3) sender_idle = 30;
            send_beat(rb_random());
         end
      end

      start <= 0;
      while (pending_hits.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      $display("run: %0d result beats, %0d hits, directed extremes and five threshold settings",
               beats_out, hits_seen);
      if (mismatches == 0) $display("tb: success");
      else begin
         $display("%0d mismatches", mismatches);
         $display("tb: failure");
      end
      $finish;
   end
endmodule
